@@ rtl/irbcd_pkg.sv @@
// Shared types and constants for the IR beam calibrated detector.
// No dependencies; used by irbcd_core and ir_beam_calibrated_detector_unit.
`default_nettype none

package irbcd_pkg;

   localparam int SENSOR_W   = 3;
   localparam int SENS_W     = 12;
   localparam int ROUNDS_W   = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   // Fraction bits of the sensitivity gain
   localparam int SENS_FRAC  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_ROUNDS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_ROUNDS  = 2'd2;

   localparam logic [SENS_W-1:0]   SENSITIVITY_RESET = 12'd128;
   localparam logic [ROUNDS_W-1:0] SKIP_ROUNDS_RESET = 10'd10;
   localparam logic [ROUNDS_W-1:0] CAL_ROUNDS_RESET  = 10'd100;

   typedef enum logic [1:0] {
      PHASE_SKIP   = 2'd0,
      PHASE_CAL    = 2'd1,
      PHASE_DETECT = 2'd2
   } phase_type;

   typedef struct packed {
      logic [SENS_W-1:0]   sensitivity;
      logic [ROUNDS_W-1:0] skip_rounds;
      logic [ROUNDS_W-1:0] calibration_rounds;
   } cfg_type;

   typedef struct packed {
      logic pressed;
      logic calibrated;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/ir_beam_calibrated_detector_unit.sv @@
// Top level of the IR beam calibrated detector: handshake, input and result
// registers, configuration registers. Depends on irbcd_pkg and irbcd_core.
//
// Usage:
//   req_* carries one sensor's ambient and lit readings per transaction;
//   rsp_* returns exactly one result per request, in order: the sensor echo,
//   pressed, and calibrated (set once the detect phase handles the item).
//   csr_we writes register csr_index (0 sensitivity, 1 skip_rounds,
//   2 calibration_rounds) from csr_data; other indexes ignored.
// Timing:
//   An accepted request waits in the input register until the result register
//   can take it; rsp_valid comes from the result register. One transaction per
//   cycle while rsp_ready is high: the input register feeds the phase logic,
//   store lookup and threshold multiply, which land in the result register.
// Reset:
//   Synchronous, active high. Phase returns to skip, item count and all
//   per-sensor maxima clear, registers return to 128, 10 and 100.
// Backpressure:
//   While rsp_ready is low the result register holds; one more request can
//   wait in the input register, after which req_ready drops.
`default_nettype none

module ir_beam_calibrated_detector_unit #(
   parameter int NUM_SENSORS = 6,
   parameter int ADC_BITS    = 12
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [irbcd_pkg::SENSOR_W-1:0]   req_sensor,
   input  wire logic [ADC_BITS-1:0]              req_ambient_reading,
   input  wire logic [ADC_BITS-1:0]              req_lit_reading,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [irbcd_pkg::SENSOR_W-1:0]   rsp_sensor_out,
   output      logic                             rsp_pressed,
   output      logic                             rsp_calibrated,
   input  wire logic                             csr_we,
   input  wire logic [irbcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [irbcd_pkg::CSR_DATA_W-1:0] csr_data
);

   irbcd_pkg::cfg_type    cfg_ff;
   irbcd_pkg::result_type result;

   logic                           in_valid_ff;
   logic [irbcd_pkg::SENSOR_W-1:0] in_sensor_ff;
   logic [ADC_BITS-1:0]            in_ambient_ff, in_lit_ff;
   logic                           out_valid_ff;
   logic [irbcd_pkg::SENSOR_W-1:0] out_sensor_ff;
   logic                           out_pressed_ff, out_calibrated_ff;
   logic                           advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensitivity        <= irbcd_pkg::SENSITIVITY_RESET;
         cfg_ff.skip_rounds        <= irbcd_pkg::SKIP_ROUNDS_RESET;
         cfg_ff.calibration_rounds <= irbcd_pkg::CAL_ROUNDS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            irbcd_pkg::CSR_SENSITIVITY: cfg_ff.sensitivity <= csr_data;
            irbcd_pkg::CSR_SKIP_ROUNDS:
               cfg_ff.skip_rounds <= csr_data[irbcd_pkg::ROUNDS_W-1:0];
            irbcd_pkg::CSR_CAL_ROUNDS:
               cfg_ff.calibration_rounds <= csr_data[irbcd_pkg::ROUNDS_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_sensor_ff  <= req_sensor;
         in_ambient_ff <= req_ambient_reading;
         in_lit_ff     <= req_lit_reading;
      end
   end

   irbcd_core #(
      .NUM_SENSORS (NUM_SENSORS),
      .ADC_BITS    (ADC_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .cfg             (cfg_ff),
      .sensor          (in_sensor_ff),
      .ambient_reading (in_ambient_ff),
      .lit_reading     (in_lit_ff),
      .result          (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_sensor_ff     <= in_sensor_ff;
         out_pressed_ff    <= result.pressed;
         out_calibrated_ff <= result.calibrated;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sensor_out = out_sensor_ff;
   assign rsp_pressed    = out_pressed_ff;
   assign rsp_calibrated = out_calibrated_ff;

endmodule

`default_nettype wire

@@ rtl/irbcd_core.sv @@
// Phase sequencing, per-sensor maximum store and press decision.
// Depends on irbcd_pkg. State advances once per transaction on step.
`default_nettype none

module irbcd_core #(
   parameter int NUM_SENSORS = 6,
   parameter int ADC_BITS    = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire irbcd_pkg::cfg_type            cfg,
   input  wire logic [irbcd_pkg::SENSOR_W-1:0] sensor,
   input  wire logic [ADC_BITS-1:0]           ambient_reading,
   input  wire logic [ADC_BITS-1:0]           lit_reading,
   output irbcd_pkg::result_type              result
);

   localparam int MAX_TOTAL = ((1 << irbcd_pkg::ROUNDS_W) - 1) * NUM_SENSORS;
   localparam int CNT_W     = $clog2(MAX_TOTAL + 1);
   localparam int THR_W     = irbcd_pkg::SENS_W + ADC_BITS - irbcd_pkg::SENS_FRAC;
   localparam int PROD_W    = irbcd_pkg::SENS_W + ADC_BITS;

   irbcd_pkg::phase_type phase_ff, phase_in, eff_phase;
   logic [CNT_W-1:0]     count_ff, count_in, eff_count;
   logic [ADC_BITS-1:0]  max_ff [NUM_SENSORS];

   logic [CNT_W-1:0]     skip_total, cal_total;
   logic                 sensor_ok;
   logic [ADC_BITS-1:0]  cur_max;
   logic [ADC_BITS:0]    diff;
   logic                 diff_neg;
   logic                 grow;
   logic [PROD_W-1:0]    product;
   logic [THR_W-1:0]     thr;

   assign skip_total = CNT_W'(cfg.skip_rounds) * CNT_W'(NUM_SENSORS);
   assign cal_total  = CNT_W'(cfg.calibration_rounds) * CNT_W'(NUM_SENSORS);

   // Next-state: a phase whose length is used up hands the item to the next phase
   always_comb begin
      eff_phase = phase_ff;
      eff_count = count_ff;
      if (eff_phase == irbcd_pkg::PHASE_SKIP && eff_count >= skip_total) begin
         eff_phase = irbcd_pkg::PHASE_CAL;
         eff_count = '0;
      end
      if (eff_phase == irbcd_pkg::PHASE_CAL && eff_count >= cal_total) begin
         eff_phase = irbcd_pkg::PHASE_DETECT;
         eff_count = '0;
      end
      phase_in = eff_phase;
      count_in = eff_count;
      if (eff_phase == irbcd_pkg::PHASE_SKIP || eff_phase == irbcd_pkg::PHASE_CAL) begin
         count_in = eff_count + CNT_W'(1);
      end
   end

   // Store read: one sensor selected per transaction
   always_comb begin
      sensor_ok = 1'b0;
      cur_max   = '0;
      for (int k = 0; k < NUM_SENSORS; k++) begin
         if (int'(sensor) == k) begin
            sensor_ok = 1'b1;
            cur_max   = max_ff[k];
         end
      end
   end

   assign diff     = {1'b0, ambient_reading} - {1'b0, lit_reading};
   assign diff_neg = diff[ADC_BITS];
   assign grow     = sensor_ok && !diff_neg && (diff[ADC_BITS-1:0] > cur_max);
   assign product  = PROD_W'(cfg.sensitivity) * PROD_W'(cur_max);
   assign thr      = product[PROD_W-1:irbcd_pkg::SENS_FRAC];

   // Outputs
   always_comb begin
      result.pressed    = 1'b0;
      result.calibrated = 1'b0;
      if (eff_phase == irbcd_pkg::PHASE_DETECT) begin
         result.calibrated = 1'b1;
         result.pressed    = sensor_ok && (diff_neg || (THR_W'(diff[ADC_BITS-1:0]) < thr));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= irbcd_pkg::PHASE_SKIP;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Store clears at reset; calibration only ever raises an entry
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
         if (reset) begin
            max_ff[k] <= '0;
         end else if (step && eff_phase == irbcd_pkg::PHASE_CAL && grow
                      && int'(sensor) == k) begin
            max_ff[k] <= diff[ADC_BITS-1:0];
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for ir_beam_calibrated_detector_unit: skip, calibration
// and detect phases under random idling, backpressure and register updates.
// Depends on irbcd_pkg and the RTL of the detector unit.
module tb_top;

   localparam int NUM_SENSORS = 6;
   localparam int ADC_W       = 12;
   localparam int RUN_LIMIT   = 2_000_000;
   localparam logic [irbcd_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [irbcd_pkg::SENSOR_W-1:0] sensor_out;
      irbcd_pkg::result_type          res;
   } detector_result_type;

   // Mirror of the detector state plus the queue of results still owed
   class detector_scoreboard;
      irbcd_pkg::cfg_type   cfg;
      irbcd_pkg::phase_type phase;
      int                   item_count;
      logic [ADC_W-1:0]     max_diff [NUM_SENSORS];
      detector_result_type  owed_q[$];
      int                   errors;
      int                   checked;
      int                   detect_seen;
      int                   pressed_seen;

      function new();
         cfg.sensitivity        = irbcd_pkg::SENSITIVITY_RESET;
         cfg.skip_rounds        = irbcd_pkg::SKIP_ROUNDS_RESET;
         cfg.calibration_rounds = irbcd_pkg::CAL_ROUNDS_RESET;
         phase        = irbcd_pkg::PHASE_SKIP;
         item_count   = 0;
         errors       = 0;
         checked      = 0;
         detect_seen  = 0;
         pressed_seen = 0;
         foreach (max_diff[k]) max_diff[k] = '0;
      endfunction

      function void write_reg(logic [irbcd_pkg::CSR_IDX_W-1:0] idx,
                              logic [irbcd_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            irbcd_pkg::CSR_SENSITIVITY:
               cfg.sensitivity = data[irbcd_pkg::SENS_W-1:0];
            irbcd_pkg::CSR_SKIP_ROUNDS:
               cfg.skip_rounds = data[irbcd_pkg::ROUNDS_W-1:0];
            irbcd_pkg::CSR_CAL_ROUNDS:
               cfg.calibration_rounds = data[irbcd_pkg::ROUNDS_W-1:0];
            default: ;
         endcase
      endfunction

      function int threshold(int idx);
         if (idx >= NUM_SENSORS) return 0;
         return (int'(cfg.sensitivity) * int'(max_diff[idx])) >> irbcd_pkg::SENS_FRAC;
      endfunction

      function void note_request(logic [irbcd_pkg::SENSOR_W-1:0] sensor,
                                 logic [ADC_W-1:0] ambient, logic [ADC_W-1:0] lit);
         int                  idx;
         int                  diff;
         int                  skip_total;
         int                  cal_total;
         bit                  in_range;
         detector_result_type r;
         idx        = sensor;
         diff       = int'(ambient) - int'(lit);
         in_range   = idx < NUM_SENSORS;
         skip_total = int'(cfg.skip_rounds) * NUM_SENSORS;
         cal_total  = int'(cfg.calibration_rounds) * NUM_SENSORS;
         r.sensor_out     = sensor;
         r.res.pressed    = 1'b0;
         r.res.calibrated = 1'b0;
         // phase length is checked before the item is handled
         if (phase == irbcd_pkg::PHASE_SKIP && item_count >= skip_total) begin
            phase      = irbcd_pkg::PHASE_CAL;
            item_count = 0;
         end
         if (phase == irbcd_pkg::PHASE_CAL && item_count >= cal_total) begin
            phase      = irbcd_pkg::PHASE_DETECT;
            item_count = 0;
         end
         case (phase)
            irbcd_pkg::PHASE_SKIP: item_count = (item_count + 1) & 'h3FFF;
            irbcd_pkg::PHASE_CAL: begin
               if (in_range && diff > int'(max_diff[idx])) max_diff[idx] = diff[ADC_W-1:0];
               item_count = (item_count + 1) & 'h3FFF;
            end
            default: begin
               r.res.calibrated = 1'b1;
               if (in_range && diff < threshold(idx)) r.res.pressed = 1'b1;
            end
         endcase
         owed_q.push_back(r);
      endfunction

      function void check_result(logic [irbcd_pkg::SENSOR_W-1:0] sensor_out, logic pressed,
                                 logic calibrated);
         detector_result_type exp_r;
         if (owed_q.size() == 0) begin
            $error("result for sensor %0d with no request outstanding", sensor_out);
            errors++;
            return;
         end
         exp_r = owed_q.pop_front();
         checked++;
         if (sensor_out !== exp_r.sensor_out) begin
            $error("sensor_out mismatch: expected %0d, actual %0d", exp_r.sensor_out,
                   sensor_out);
            errors++;
         end
         if (pressed !== exp_r.res.pressed) begin
            $error("pressed mismatch: expected %0d, actual %0d", exp_r.res.pressed, pressed);
            errors++;
         end
         if (calibrated !== exp_r.res.calibrated) begin
            $error("calibrated mismatch: expected %0d, actual %0d", exp_r.res.calibrated,
                   calibrated);
            errors++;
         end
         if (exp_r.res.calibrated) detect_seen++;
         if (exp_r.res.pressed) pressed_seen++;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [irbcd_pkg::SENSOR_W-1:0]    req_sensor;
   logic [ADC_W-1:0]                  req_ambient_reading;
   logic [ADC_W-1:0]                  req_lit_reading;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [irbcd_pkg::SENSOR_W-1:0]    rsp_sensor_out;
   logic                              rsp_pressed;
   logic                              rsp_calibrated;
   logic                              csr_we;
   logic [irbcd_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [irbcd_pkg::CSR_DATA_W-1:0]  csr_data;

   detector_scoreboard sb;
   int send_idle_pct;
   int stall_pct;
   int hold_left;
   int reg_writes;

   ir_beam_calibrated_detector_unit #(
      .NUM_SENSORS(NUM_SENSORS),
      .ADC_BITS   (ADC_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sensor         (req_sensor),
      .req_ambient_reading(req_ambient_reading),
      .req_lit_reading    (req_lit_reading),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sensor_out     (rsp_sensor_out),
      .rsp_pressed        (rsp_pressed),
      .rsp_calibrated     (rsp_calibrated),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("ir_beam_calibrated_detector_unit test failed");
      $finish;
   end

   // Receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_sensor_out, rsp_pressed, rsp_calibrated);
   end

   // All driving tasks start and end just after a falling edge
   task automatic send_reading(input logic [irbcd_pkg::SENSOR_W-1:0] sensor,
                               input logic [ADC_W-1:0] ambient, input logic [ADC_W-1:0] lit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_sensor          = sensor;
      req_ambient_reading = ambient;
      req_lit_reading     = lit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(sensor, ambient, lit);
      @(negedge clock);
   endtask

   // Pick random readings whose ambient - lit difference is the one given, clamped to +/-4095
   task automatic send_diff(input int sensor, input int diff);
      int               d;
      logic [ADC_W-1:0] ambient;
      logic [ADC_W-1:0] lit;
      d = diff;
      if (d > 4095) d = 4095;
      if (d < -4095) d = -4095;
      if (d >= 0) begin
         lit     = ADC_W'($urandom_range(0, 4095 - d));
         ambient = ADC_W'(int'(lit) + d);
      end else begin
         ambient = ADC_W'($urandom_range(0, 4095 + d));
         lit     = ADC_W'(int'(ambient) - d);
      end
      send_reading(irbcd_pkg::SENSOR_W'(sensor), ambient, lit);
   endtask

   task automatic send_noise();
      send_reading(irbcd_pkg::SENSOR_W'($urandom_range(0, 7)),
                   ADC_W'($urandom_range(0, 4095)), ADC_W'($urandom_range(0, 4095)));
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [irbcd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [irbcd_pkg::CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      sb.write_reg(idx, data);
      reg_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      int cap [NUM_SENSORS];
      int r;
      int s;
      sb                  = new();
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_sensor          = '0;
      req_ambient_reading = '0;
      req_lit_reading     = '0;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_data            = '0;
      send_idle_pct       = 0;
      stall_pct           = 0;
      hold_left           = 0;
      reg_writes          = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // skip phase under reset settings, then stretch it to the maximum
      send_reading(3'd0, 12'd0, 12'd0);
      send_reading(3'd1, 12'd4095, 12'd4095);
      send_reading(3'd5, 12'd4095, 12'd0);
      send_reading(3'd7, 12'd0, 12'd4095);
      drain();
      write_reg(irbcd_pkg::CSR_SKIP_ROUNDS, 12'hFFF);
      send_noise();
      send_noise();
      drain();
      // zero skip length: next transaction calibrates
      write_reg(irbcd_pkg::CSR_SKIP_ROUNDS, 12'h000);
      write_reg(irbcd_pkg::CSR_CAL_ROUNDS, 12'h3FF);
      write_reg(irbcd_pkg::CSR_SENSITIVITY, 12'd256);

      send_reading(3'd0, 12'd4095, 12'd0);
      send_reading(3'd1, 12'd0, 12'd4095);
      send_reading(3'd6, 12'd4095, 12'd0);
      send_reading(3'd7, 12'd4095, 12'd0);
      send_reading(3'd2, 12'd1000, 12'd1000);
      send_reading(3'd3, 12'd2000, 12'd1500);
      send_reading(3'd3, 12'd2000, 12'd1800);
      send_reading(3'd4, 12'd300, 12'd100);
      drain();
      // shorten calibration so it ends on its own during the random stream
      write_reg(irbcd_pkg::CSR_CAL_ROUNDS, 12'd26);

      foreach (cap[k]) cap[k] = $urandom_range(50, 4095);
      send_idle_pct = 23;
      stall_pct     = 23;
      while (sb.phase != irbcd_pkg::PHASE_DETECT) begin
         r = $urandom_range(99);
         s = $urandom_range(0, NUM_SENSORS - 1);
         if (r < 80) send_diff(s, $urandom_range(0, cap[s]));
         else if (r < 95) send_reading(irbcd_pkg::SENSOR_W'(s),
                                       ADC_W'($urandom_range(0, 4095)),
                                       ADC_W'($urandom_range(0, 4095)));
         else send_reading(irbcd_pkg::SENSOR_W'($urandom_range(6, 7)),
                           ADC_W'($urandom_range(0, 4095)),
                           ADC_W'($urandom_range(0, 4095)));
      end
      drain();

      // detection edge cases; sensor 0 holds the full-scale maximum
      send_idle_pct = 0;
      stall_pct     = 0;
      send_diff(0, 4094);
      send_diff(0, 4095);
      send_diff(6, -100);
      send_diff(7, -100);
      drain();
      write_reg(irbcd_pkg::CSR_SENSITIVITY, 12'd0);
      send_diff(1, -1);
      send_diff(1, 0);
      send_reading(3'd2, 12'd0, 12'd0);
      drain();
      write_reg(irbcd_pkg::CSR_SENSITIVITY, 12'd4095);
      send_diff(0, 4095);
      send_diff(3, sb.threshold(3) - 1);
      send_diff(3, sb.threshold(3));
      drain();
      // lengths no longer matter once detecting; unmapped index is ignored
      write_reg(irbcd_pkg::CSR_CAL_ROUNDS, 12'h000);
      write_reg(irbcd_pkg::CSR_SKIP_ROUNDS, 12'hC05);
      write_reg(CSR_UNMAPPED, 12'hFFF);

      for (int blk = 0; blk < 12; blk++) begin
         drain();
         case (blk % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 63; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         if (blk % 3 == 0)
            write_reg(irbcd_pkg::CSR_SENSITIVITY,
                      irbcd_pkg::CSR_DATA_W'($urandom_range(0, 4095)));
         else
            write_reg(irbcd_pkg::CSR_SENSITIVITY,
                      irbcd_pkg::CSR_DATA_W'($urandom_range(0, 511)));
         if (blk % 5 == 4) begin
            write_reg(irbcd_pkg::CSR_SKIP_ROUNDS,
                      irbcd_pkg::CSR_DATA_W'($urandom_range(0, 4095)));
            write_reg(irbcd_pkg::CSR_CAL_ROUNDS,
                      irbcd_pkg::CSR_DATA_W'($urandom_range(0, 4095)));
            write_reg(CSR_UNMAPPED, irbcd_pkg::CSR_DATA_W'($urandom_range(0, 4095)));
         end
         // long receiver hold-off: input side fills and backs up
         if (blk == 5) begin
            send_idle_pct = 0;
            hold_left     = 300;
         end
         for (int n = 0; n < 65; n++) begin
            r = $urandom_range(99);
            s = $urandom_range(0, NUM_SENSORS - 1);
            if (r < 70) send_diff(s, sb.threshold(s) + int'($urandom_range(0, 16)) - 8);
            else if (r < 90) send_noise();
            else send_diff(s, int'($urandom_range(0, 8190)) - 4095);
         end
      end

      drain();
      repeat (10) @(negedge clock);
      $display("Checked %0d transactions through skip, calibration and detection;",
               sb.checked);
      $display("%0d handled while detecting, %0d pressed, %0d register writes.",
               sb.detect_seen, sb.pressed_seen, reg_writes);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ir_beam_calibrated_detector_unit test passed");
      end else begin
         $display("ir_beam_calibrated_detector_unit test failed");
      end
      $finish;
   end

endmodule

@@ ir_beam_calibrated_detector_unit.f @@
rtl/irbcd_pkg.sv
rtl/irbcd_core.sv
rtl/ir_beam_calibrated_detector_unit.sv
tb/sv/tb_top.sv
